// ===== hw/rtl/pce_pkg.sv =====
package pce_pkg;

    localparam int COORD_W  = 32;
    localparam int CHG_W    = 24;
    localparam int SIG_W    = 20;
    localparam int EPS_W    = 20;
    localparam int BOX_W    = 31;
    localparam int ENERGY_W = 64;
    localparam int DIST_W   = 32;

    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * DIST_W;
    localparam int SIGSUM_W  = SIG_W + 1;
    localparam int CHGP_W    = 2 * CHG_W;
    localparam int EPSP_W    = 2 * EPS_W;
    localparam int EROOT_W   = (EPSP_W + 16) / 2;
    localparam int CNUM_W    = (CHGP_W - 1) + 16;
    localparam int XNUM_W    = SIGSUM_W + 31;
    localparam int PROD_W    = ENERGY_W + EROOT_W;

    // pipeline depths, in register stages
    localparam int LAT_FRONT = 4;
    localparam int LAT_ROOT  = DIST_W;
    localparam int LAT_EROOT = EROOT_W;
    localparam int LAT_MUL   = 3;
    localparam int LAT_LJ    = XNUM_W + 4 * LAT_MUL + 3;
    localparam int ER_DLY    = XNUM_W + 4 * LAT_MUL + 1;
    localparam int CQ_DLY    = LAT_LJ - CNUM_W;
    localparam int LAT_TOTAL = LAT_FRONT + LAT_ROOT + LAT_LJ + 2;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
    localparam logic [ENERGY_W-1:0] ENERGY_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

    typedef enum logic [1:0] {
        REG_BOX_X = 2'd0,
        REG_BOX_Y = 2'd1,
        REG_BOX_Z = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [BOX_W-1:0] x;
        logic [BOX_W-1:0] y;
        logic [BOX_W-1:0] z;
    } box_t;

endpackage

// ===== hw/rtl/pce_delay.sv =====
module pce_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= din;
            for (int k = 1; k < DEPTH; k++) begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

// ===== hw/rtl/pce_isqrt.sv =====
module pce_isqrt #(
    parameter int IN_W = 64
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [IN_W-1:0]   din,
    output logic [IN_W/2-1:0] root
);

    localparam int OUT_W = IN_W / 2;
    localparam int RW    = OUT_W + 3;

    logic [RW-1:0]    rem_reg  [OUT_W];
    logic [OUT_W-1:0] root_reg [OUT_W];
    logic [IN_W-1:0]  val_reg  [OUT_W];

    // one result bit per stage, two radicand bits consumed per stage
    for (genvar k = 0; k < OUT_W; k++) begin : g_step
        logic [RW-1:0]    rem_in, rem_sh, trial, rem_next;
        logic [OUT_W-1:0] root_in, root_next;
        logic [IN_W-1:0]  val_in;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = din;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign val_in  = val_reg[k-1];
        end

        always_comb begin
            rem_sh = {rem_in[RW-3:0], val_in[IN_W-1 -: 2]};
            trial  = {1'b0, root_in, 2'b01};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[OUT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_in[OUT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                val_reg[k]  <= {val_in[IN_W-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[OUT_W-1];

endmodule

// ===== hw/rtl/pce_div.sv =====
module pce_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] nq_reg  [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];

    // restoring division: dividend bits shift out the top, quotient bits in the bottom
    for (genvar k = 0; k < NUM_W; k++) begin : g_step
        logic [DEN_W-1:0] rem_in, den_in, rem_next;
        logic [NUM_W-1:0] nq_in;
        logic [DEN_W:0]   rem_sh, rem_diff;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = num;
            assign den_in = den;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign nq_in  = nq_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        always_comb begin
            rem_sh   = {rem_in, nq_in[NUM_W-1]};
            rem_diff = rem_sh - {1'b0, den_in};
            ge       = rem_sh >= {1'b0, den_in};
            rem_next = ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                nq_reg[k]  <= {nq_in[NUM_W-2:0], ge};
                den_reg[k] <= den_in;
            end
        end
    end

    assign quo = nq_reg[NUM_W-1];

endmodule

// ===== hw/rtl/pce_mulq.sv =====
module pce_mulq (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    input  logic        ovf_in,
    output logic [63:0] q,
    output logic        ovf_out
);

    logic [63:0] ll_reg, lh_reg, hl_reg, hh_reg;
    logic        ovf1_reg;
    logic [33:0] mid_reg;
    logic [63:0] hip_reg;
    logic        ovf2_reg;
    logic [63:0] hi_next;
    logic        big_next;
    logic [63:0] q_reg;
    logic        ovf3_reg;

    always_comb begin
        hi_next  = hip_reg + {62'd0, mid_reg[33:32]};
        big_next = hi_next[63:32] != 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg   <= a[31:0]  * b[31:0];
            lh_reg   <= a[31:0]  * b[63:32];
            hl_reg   <= a[63:32] * b[31:0];
            hh_reg   <= a[63:32] * b[63:32];
            ovf1_reg <= ovf_in;

            mid_reg  <= {2'b00, ll_reg[63:32]} + {2'b00, lh_reg[31:0]}
                        + {2'b00, hl_reg[31:0]};
            hip_reg  <= hh_reg + {32'd0, lh_reg[63:32]} + {32'd0, hl_reg[63:32]};
            ovf2_reg <= ovf1_reg;

            // saturate once the integer part no longer fits
            q_reg    <= big_next ? '1 : {hi_next[31:0], mid_reg[31:0]};
            ovf3_reg <= ovf2_reg | big_next;
        end
    end

    assign q       = q_reg;
    assign ovf_out = ovf3_reg;

endmodule

// ===== hw/rtl/pce_front.sv =====
module pce_front (
    input  logic                                aclk,
    input  logic                                en,
    input  pce_pkg::box_t                       box,
    input  logic signed [pce_pkg::COORD_W-1:0]  ax,
    input  logic signed [pce_pkg::COORD_W-1:0]  ay,
    input  logic signed [pce_pkg::COORD_W-1:0]  az,
    input  logic signed [pce_pkg::COORD_W-1:0]  bx,
    input  logic signed [pce_pkg::COORD_W-1:0]  by,
    input  logic signed [pce_pkg::COORD_W-1:0]  bz,
    input  logic signed [pce_pkg::CHG_W-1:0]    qa,
    input  logic signed [pce_pkg::CHG_W-1:0]    qb,
    input  logic [pce_pkg::SIG_W-1:0]           sa,
    input  logic [pce_pkg::SIG_W-1:0]           sb,
    input  logic [pce_pkg::EPS_W-1:0]           ea,
    input  logic [pce_pkg::EPS_W-1:0]           eb,
    output logic [pce_pkg::SQ_W-1:0]            sq_sum,
    output logic                                far,
    output logic signed [pce_pkg::CHGP_W-1:0]   chg_prod,
    output logic [pce_pkg::SIGSUM_W-1:0]        sig_sum,
    output logic [pce_pkg::EPSP_W-1:0]          eps_prod
);

    import pce_pkg::*;

    function automatic logic signed [DIFF_W-1:0] wrap_axis(
        input logic signed [DIFF_W-1:0] d,
        input logic [BOX_W-1:0]         len
    );
        logic signed [DIFF_W:0] d2, bl, dx, dw;
        d2 = {d, 1'b0};
        bl = {2'b00, len};
        dx = {d[DIFF_W-1], d};
        if (d2 > bl) begin
            dw = dx - bl;
        end else if (d2 < -bl) begin
            dw = dx + bl;
        end else begin
            dw = dx;
        end
        return dw[DIFF_W-1:0];
    endfunction

    logic signed [DIFF_W-1:0]   d_reg  [3];
    logic signed [DIFF_W-1:0]   w_reg  [3];
    logic [SQ_W-1:0]            sq_reg [3];
    logic [SQ_W+1:0]            sum_reg;
    logic [BOX_W-1:0]           box_len [3];
    logic signed [2*DIFF_W-1:0] sq_full [3];

    logic signed [CHGP_W-1:0]   chg_reg [LAT_FRONT];
    logic [SIGSUM_W-1:0]        sig_reg [LAT_FRONT];
    logic [EPSP_W-1:0]          eps_reg [LAT_FRONT];

    always_comb begin
        box_len[0] = box.x;
        box_len[1] = box.y;
        box_len[2] = box.z;
        for (int i = 0; i < 3; i++) begin
            sq_full[i] = w_reg[i] * w_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg[0] <= {ax[COORD_W-1], ax} - {bx[COORD_W-1], bx};
            d_reg[1] <= {ay[COORD_W-1], ay} - {by[COORD_W-1], by};
            d_reg[2] <= {az[COORD_W-1], az} - {bz[COORD_W-1], bz};
            for (int i = 0; i < 3; i++) begin
                w_reg[i]  <= wrap_axis(d_reg[i], box_len[i]);
                sq_reg[i] <= sq_full[i][SQ_W-1:0];
            end
            sum_reg <= {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};

            chg_reg[0] <= qa * qb;
            sig_reg[0] <= {1'b0, sa} + {1'b0, sb};
            eps_reg[0] <= ea * eb;
            for (int k = 1; k < LAT_FRONT; k++) begin
                chg_reg[k] <= chg_reg[k-1];
                sig_reg[k] <= sig_reg[k-1];
                eps_reg[k] <= eps_reg[k-1];
            end
        end
    end

    assign sq_sum   = sum_reg[SQ_W-1:0];
    assign far      = sum_reg[SQ_W+1:SQ_W] != 2'b00;
    assign chg_prod = chg_reg[LAT_FRONT-1];
    assign sig_sum  = sig_reg[LAT_FRONT-1];
    assign eps_prod = eps_reg[LAT_FRONT-1];

endmodule

// ===== hw/rtl/pair_coulomb_lj_energy_top.sv =====
// Pair energy pipeline: Coulomb plus Lennard-Jones energy of one atom pair
// under the minimum image rule, in fixed point.
//
// Input channel s_*: one request per atom pair, taken when s_valid and
// s_ready are high. Result channel m_*: one result per request, in order.
// Configuration: box lengths written through cfg_wr_en / cfg_addr /
// cfg_wr_data while the pipeline is empty; a zero length turns the wrap off.
//
// Latency from acceptance to m_valid is set by the 32-step distance
// square root, the 52-step sigma/r divider and the four three-stage
// Q32.32 multiplies that build the twelfth power; the 63-step Coulomb
// divider runs alongside. A request is taken every cycle s_ready is high.
//
// The whole pipeline advances together: s_ready = !m_valid || m_ready.
// While the receiver stalls a held result, every stage freezes, nothing
// is dropped or repeated. Reset clears all valid bits and the box lengths.
module pair_coulomb_lj_energy_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [1:0]                          cfg_addr,
    input  logic [pce_pkg::BOX_W-1:0]           cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [pce_pkg::COORD_W-1:0]  s_first_x,
    input  logic signed [pce_pkg::COORD_W-1:0]  s_first_y,
    input  logic signed [pce_pkg::COORD_W-1:0]  s_first_z,
    input  logic signed [pce_pkg::CHG_W-1:0]    s_first_charge,
    input  logic [pce_pkg::SIG_W-1:0]           s_first_sigma,
    input  logic [pce_pkg::EPS_W-1:0]           s_first_epsilon,
    input  logic signed [pce_pkg::COORD_W-1:0]  s_second_x,
    input  logic signed [pce_pkg::COORD_W-1:0]  s_second_y,
    input  logic signed [pce_pkg::COORD_W-1:0]  s_second_z,
    input  logic signed [pce_pkg::CHG_W-1:0]    s_second_charge,
    input  logic [pce_pkg::SIG_W-1:0]           s_second_sigma,
    input  logic [pce_pkg::EPS_W-1:0]           s_second_epsilon,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [pce_pkg::ENERGY_W-1:0] m_total_energy,
    output logic signed [pce_pkg::ENERGY_W-1:0] m_coulomb_energy,
    output logic signed [pce_pkg::ENERGY_W-1:0] m_lj_energy,
    output logic [pce_pkg::DIST_W-1:0]          m_pair_distance,
    output logic                                m_zero_distance,
    output logic                                m_saturated
);

    import pce_pkg::*;

    localparam int SIDE_W = DIST_W + 4;

    logic en;
    box_t box_reg;

    logic [LAT_TOTAL-2:0] vld_reg;
    logic                 m_valid_reg;

    // front end outputs
    logic [SQ_W-1:0]          sq_sum;
    logic                     far;
    logic signed [CHGP_W-1:0] chg_prod;
    logic [SIGSUM_W-1:0]      sig_sum;
    logic [EPSP_W-1:0]        eps_prod;

    // aligned at the end of the square root
    logic [DIST_W-1:0]        root;
    logic                     far_d;
    logic signed [CHGP_W-1:0] chg_d;
    logic [SIGSUM_W-1:0]      sig_d;
    logic [EROOT_W-1:0]       er_raw, er_d;
    logic [DIST_W-1:0]        pair_dist;
    logic [CHGP_W-1:0]        chg_mag;
    logic                     chg_neg, chg_zero;
    logic [SIDE_W-1:0]        side_in, side_out;

    logic [CNUM_W-1:0]  cq, cq_d;
    logic [XNUM_W-1:0]  xq;
    logic [63:0]        x64, x_d, x2, x3, x6, x6_d, x12;
    logic               ovf2, ovf3, ovf6, ovf12;
    logic [EROOT_W-1:0] er_mul;

    logic [63:0]        diff_reg;
    logic               neg1_reg, ovf1_reg;
    logic [59:0]        pp_lo_reg, pp_hi_reg;
    logic               neg2_reg, ovf2_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               neg3_reg, ovf3_reg;

    logic [ENERGY_W-1:0] coul_next, lj_next, coul_reg, lj_reg, lj_mag;
    logic                sat_next, sat_reg, zero_next, zero_reg;
    logic [DIST_W-1:0]   dist_reg;
    logic [DIST_W-1:0]   side_dist;
    logic                side_pneg, side_pzero, side_snz, side_enz;
    logic [ENERGY_W:0]   total_sum;

    logic [ENERGY_W-1:0] total_out_reg, coul_out_reg, lj_out_reg;
    logic [DIST_W-1:0]   dist_out_reg;
    logic                zero_out_reg, sat_out_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_BOX_X: box_reg.x <= cfg_wr_data;
                REG_BOX_Y: box_reg.y <= cfg_wr_data;
                REG_BOX_Z: box_reg.z <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[LAT_TOTAL-3:0], s_valid};
            m_valid_reg <= vld_reg[LAT_TOTAL-2];
        end
    end

    pce_front u_front (
        .aclk     (aclk),
        .en       (en),
        .box      (box_reg),
        .ax       (s_first_x),
        .ay       (s_first_y),
        .az       (s_first_z),
        .bx       (s_second_x),
        .by       (s_second_y),
        .bz       (s_second_z),
        .qa       (s_first_charge),
        .qb       (s_second_charge),
        .sa       (s_first_sigma),
        .sb       (s_second_sigma),
        .ea       (s_first_epsilon),
        .eb       (s_second_epsilon),
        .sq_sum   (sq_sum),
        .far      (far),
        .chg_prod (chg_prod),
        .sig_sum  (sig_sum),
        .eps_prod (eps_prod)
    );

    pce_isqrt #(.IN_W(SQ_W)) u_dist_root (
        .aclk (aclk),
        .en   (en),
        .din  (sq_sum),
        .root (root)
    );

    pce_isqrt #(.IN_W(2 * EROOT_W)) u_eps_root (
        .aclk (aclk),
        .en   (en),
        .din  ({eps_prod, 16'd0}),
        .root (er_raw)
    );

    pce_delay #(.WIDTH(1), .DEPTH(LAT_ROOT)) u_far_dly (
        .aclk (aclk), .en (en), .din (far), .dout (far_d)
    );

    pce_delay #(.WIDTH(CHGP_W), .DEPTH(LAT_ROOT)) u_chg_dly (
        .aclk (aclk), .en (en), .din (chg_prod), .dout (chg_d)
    );

    pce_delay #(.WIDTH(SIGSUM_W), .DEPTH(LAT_ROOT)) u_sig_dly (
        .aclk (aclk), .en (en), .din (sig_sum), .dout (sig_d)
    );

    pce_delay #(.WIDTH(EROOT_W), .DEPTH(LAT_ROOT - LAT_EROOT)) u_er_dly (
        .aclk (aclk), .en (en), .din (er_raw), .dout (er_d)
    );

    always_comb begin
        pair_dist = far_d ? '1 : root;
        chg_neg   = chg_d[CHGP_W-1];
        chg_zero  = chg_d == '0;
        chg_mag   = chg_neg ? CHGP_W'(-chg_d) : CHGP_W'(chg_d);
        side_in   = {pair_dist, chg_neg, chg_zero, sig_d != '0, er_d != '0};
    end

    pce_div #(.NUM_W(CNUM_W), .DEN_W(DIST_W)) u_coul_div (
        .aclk (aclk),
        .en   (en),
        .num  ({chg_mag[CHGP_W-2:0], 16'd0}),
        .den  (pair_dist),
        .quo  (cq)
    );

    pce_div #(.NUM_W(XNUM_W), .DEN_W(DIST_W)) u_ratio_div (
        .aclk (aclk),
        .en   (en),
        .num  ({sig_d, 31'd0}),
        .den  (pair_dist),
        .quo  (xq)
    );

    pce_delay #(.WIDTH(SIDE_W), .DEPTH(LAT_LJ)) u_side_dly (
        .aclk (aclk), .en (en), .din (side_in), .dout (side_out)
    );

    pce_delay #(.WIDTH(EROOT_W), .DEPTH(ER_DLY)) u_er_mul_dly (
        .aclk (aclk), .en (en), .din (er_d), .dout (er_mul)
    );

    pce_delay #(.WIDTH(CNUM_W), .DEPTH(CQ_DLY)) u_cq_dly (
        .aclk (aclk), .en (en), .din (cq), .dout (cq_d)
    );

    assign x64 = {{(64 - XNUM_W){1'b0}}, xq};

    pce_mulq u_mul_x2 (
        .aclk (aclk), .en (en), .a (x64), .b (x64), .ovf_in (1'b0),
        .q (x2), .ovf_out (ovf2)
    );

    pce_delay #(.WIDTH(64), .DEPTH(LAT_MUL)) u_x_dly (
        .aclk (aclk), .en (en), .din (x64), .dout (x_d)
    );

    pce_mulq u_mul_x3 (
        .aclk (aclk), .en (en), .a (x2), .b (x_d), .ovf_in (ovf2),
        .q (x3), .ovf_out (ovf3)
    );

    pce_mulq u_mul_x6 (
        .aclk (aclk), .en (en), .a (x3), .b (x3), .ovf_in (ovf3),
        .q (x6), .ovf_out (ovf6)
    );

    pce_delay #(.WIDTH(64), .DEPTH(LAT_MUL)) u_x6_dly (
        .aclk (aclk), .en (en), .din (x6), .dout (x6_d)
    );

    pce_mulq u_mul_x12 (
        .aclk (aclk), .en (en), .a (x6), .b (x6), .ovf_in (ovf6),
        .q (x12), .ovf_out (ovf12)
    );

    // difference of powers, then scale by the combined well depth
    always_ff @(posedge aclk) begin
        if (en) begin
            neg1_reg  <= x12 < x6_d;
            diff_reg  <= (x12 < x6_d) ? x6_d - x12 : x12 - x6_d;
            ovf1_reg  <= ovf12;

            pp_lo_reg <= diff_reg[31:0]  * er_mul;
            pp_hi_reg <= diff_reg[63:32] * er_mul;
            neg2_reg  <= neg1_reg;
            ovf2_reg  <= ovf1_reg;

            prod_reg  <= {pp_hi_reg, 32'd0} + {32'd0, pp_lo_reg};
            neg3_reg  <= neg2_reg;
            ovf3_reg  <= ovf2_reg;
        end
    end

    always_comb begin
        {side_dist, side_pneg, side_pzero, side_snz, side_enz} = side_out;
        zero_next = side_dist == '0;
        lj_mag    = prod_reg[ENERGY_W+21:22];
        sat_next  = 1'b0;
        if (zero_next) begin
            if (side_pneg) begin
                coul_next = ENERGY_MIN;
                sat_next  = 1'b1;
            end else if (side_pzero) begin
                coul_next = '0;
            end else begin
                coul_next = ENERGY_MAX;
                sat_next  = 1'b1;
            end
            if (side_enz && side_snz) begin
                lj_next  = ENERGY_MAX;
                sat_next = 1'b1;
            end else begin
                lj_next = '0;
            end
        end else begin
            coul_next = side_pneg ? ENERGY_W'(0) - {1'b0, cq_d} : {1'b0, cq_d};
            if (!side_enz) begin
                lj_next = '0;
            end else if (ovf3_reg || (!neg3_reg && prod_reg[PROD_W-1:ENERGY_W+21] != '0))
            begin
                lj_next  = ENERGY_MAX;
                sat_next = 1'b1;
            end else begin
                lj_next = neg3_reg ? ENERGY_W'(0) - lj_mag : lj_mag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            coul_reg <= coul_next;
            lj_reg   <= lj_next;
            sat_reg  <= sat_next;
            zero_reg <= zero_next;
            dist_reg <= side_dist;
        end
    end

    assign total_sum = {coul_reg[ENERGY_W-1], coul_reg} + {lj_reg[ENERGY_W-1], lj_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            if (total_sum[ENERGY_W] != total_sum[ENERGY_W-1]) begin
                total_out_reg <= total_sum[ENERGY_W] ? ENERGY_MIN : ENERGY_MAX;
                sat_out_reg   <= 1'b1;
            end else begin
                total_out_reg <= total_sum[ENERGY_W-1:0];
                sat_out_reg   <= sat_reg;
            end
            coul_out_reg <= coul_reg;
            lj_out_reg   <= lj_reg;
            dist_out_reg <= dist_reg;
            zero_out_reg <= zero_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_total_energy   = total_out_reg;
    assign m_coulomb_energy = coul_out_reg;
    assign m_lj_energy      = lj_out_reg;
    assign m_pair_distance  = dist_out_reg;
    assign m_zero_distance  = zero_out_reg;
    assign m_saturated      = sat_out_reg;

endmodule

// ===== hw/rtl/pce_checker.sv =====
module pce_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_total_energy,
    input logic [63:0] m_coulomb_energy,
    input logic [63:0] m_lj_energy,
    input logic [31:0] m_pair_distance,
    input logic        m_zero_distance,
    input logic        m_saturated
);

    a_zero_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_zero_distance == (m_pair_distance == 32'd0)))
        else $error("zero_distance disagrees with pair_distance");

    a_total_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_saturated |-> m_total_energy == m_coulomb_energy + m_lj_energy)
        else $error("unsaturated total is not coulomb plus lj");

    a_zero_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_distance && (m_coulomb_energy != 64'd0 || m_lj_energy != 64'd0)
        |-> m_saturated)
        else $error("clamped zero-distance energy without saturated flag");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total_energy))
        else $error("stalled result changed");

endmodule

bind pair_coulomb_lj_energy_top pce_checker u_pce_checker (.*);
